[hw/rtl/btsp_pkg.sv]
package btsp_pkg;

    // Longest long-form length field accepted, in bytes (1 or 2)
    localparam int unsigned MaxLengthBytes = 2;

    localparam logic [7:0]  FillZero     = 8'h00;
    localparam logic [7:0]  FillOnes     = 8'hFF;
    localparam logic [4:0]  TagMultiMask = 5'h1F;
    localparam logic [7:0]  LenLongFlag  = 8'h80;
    localparam logic [15:0] PosMax       = 16'hFFFF;
    localparam int unsigned ConsBit      = 5;

    // Register indexes on the config port
    localparam logic RegSearchEnable = 1'b0;
    localparam logic RegSearchTag    = 1'b1;

    typedef enum logic [2:0] {
        PH_SKIP  = 3'd0,
        PH_TAG2  = 3'd1,
        PH_LEN0  = 3'd2,
        PH_LENX  = 3'd3,
        PH_VALUE = 3'd4,
        PH_HALT  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_END    = 3'd1,
        ST_TRUNC  = 3'd2,
        ST_BADTAG = 3'd3,
        ST_BADLEN = 3'd4
    } t_status;

    typedef struct packed {
        logic        search_enable;
        logic [15:0] search_tag;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] tag_value;
        logic        constructed;
        logic [15:0] value_length;
        logic [15:0] value_offset;
        logic        run_last;
    } t_result;

    // Results produced by one accepted byte: none, one (a) or two (a then b)
    typedef struct packed {
        logic    push_one;
        logic    push_two;
        t_result a;
        t_result b;
    } t_push;

endpackage

[hw/rtl/btsp_intf.sv]
interface btsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface btsp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] tag_value;
    logic        constructed;
    logic [15:0] value_length;
    logic [15:0] value_offset;
    logic        run_last;

    modport source (output valid, output status, output tag_value, output constructed,
                    output value_length, output value_offset, output run_last,
                    input ready);
    modport sink   (input valid, input status, input tag_value, input constructed,
                    input value_length, input value_offset, input run_last,
                    output ready);
endinterface

[hw/rtl/ber_tlv_stream_parser.sv]
// BER-TLV stream parser.
// i_byte carries the buffer one byte per beat (data_byte, last_byte on the
// final byte). o_res carries result beats: status, tag_value, constructed,
// value_length, value_offset and run_last, which marks the final result
// caused by one input byte. A byte causes zero, one or two results.
// The APB port holds search_enable at 0x0 and search_tag at 0x4; write them
// only while the parser is idle.
// A result is written into the output queue when the byte that causes it is
// accepted and is offered once it reaches the head. Bytes are taken one per
// cycle while the queue has room; the parser state updates once per byte and
// results enter a four-entry output queue. A byte that causes two results (an
// object closed by the final byte, followed by its end result) writes both.
// i_byte.ready stays high while the queue has room for two results. With the
// receiver stalled, input stops once three results are waiting; bytes that
// cause no result pass freely until then, and no result is dropped.
// Reset (synchronous, active low) empties the queue, clears both registers
// and returns the parser to the start of a buffer.
module ber_tlv_stream_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    btsp_byte_if.sink     i_byte,
    btsp_res_if.source    o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    btsp_pkg::t_cfg  w_cfg;
    btsp_pkg::t_push w_push;
    logic            w_space;
    logic            w_accept;

    assign i_byte.ready = w_space;
    assign w_accept     = i_byte.valid && w_space;

    btsp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    btsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_byte.data_byte),
        .i_last_byte (i_byte.last_byte),
        .i_cfg       (w_cfg),
        .o_push      (w_push)
    );

    btsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_space (w_space),
        .o_res   (o_res)
    );

endmodule

[hw/rtl/btsp_regs.sv]
module btsp_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output btsp_pkg::t_cfg    o_cfg
);

    logic        r_search_enable;
    logic [15:0] r_search_tag;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    // register writes, word index from paddr[2]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_enable <= 1'b0;
            r_search_tag    <= '0;
        end else if (w_wr) begin
            if (paddr[2] == btsp_pkg::RegSearchEnable) begin
                r_search_enable <= pwdata[0];
            end else begin
                r_search_tag <= pwdata[15:0];
            end
        end
    end

    // read back
    always_comb begin
        if (paddr[2] == btsp_pkg::RegSearchTag) begin
            prdata = {16'b0, r_search_tag};
        end else begin
            prdata = {31'b0, r_search_enable};
        end
    end

    assign o_cfg.search_enable = r_search_enable;
    assign o_cfg.search_tag    = r_search_tag;

endmodule

[hw/rtl/btsp_core.sv]
module btsp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  btsp_pkg::t_cfg    i_cfg,
    output btsp_pkg::t_push   o_push
);

    btsp_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_position, n_position;
    logic [15:0]      r_tag, n_tag;
    logic             r_cons, n_cons;
    logic [15:0]      r_length, n_length;
    logic [1:0]       r_len_left, n_len_left;
    logic [15:0]      r_value_start, n_value_start;
    logic [15:0]      r_value_left, n_value_left;

    btsp_pkg::t_phase w_mid_phase;
    logic             w_ovf, w_filler, w_badtag, w_badlen;
    logic             w_start, w_finish, w_match, w_report;
    logic [15:0]      w_new_len;
    logic             w_prim, w_tail;
    btsp_pkg::t_result w_prim_res, w_tail_res;

    // shared decode of the current byte
    assign w_ovf    = (r_phase != btsp_pkg::PH_HALT) && (r_position == btsp_pkg::PosMax);
    assign w_filler = (i_data_byte == btsp_pkg::FillZero) ||
                      (i_data_byte == btsp_pkg::FillOnes);
    assign w_badtag = !w_ovf && (r_phase == btsp_pkg::PH_TAG2) && i_data_byte[7];
    assign w_badlen = !w_ovf && (r_phase == btsp_pkg::PH_LEN0) && i_data_byte[7] &&
                      ((i_data_byte == btsp_pkg::LenLongFlag) ||
                       (i_data_byte == btsp_pkg::FillOnes) ||
                       (i_data_byte[6:0] > 7'(btsp_pkg::MaxLengthBytes)));
    assign w_new_len = (r_phase == btsp_pkg::PH_LEN0) ? {8'b0, i_data_byte}
                                                      : {r_length[7:0], i_data_byte};
    assign w_start  = !w_ovf &&
                      (((r_phase == btsp_pkg::PH_LEN0) && !i_data_byte[7]) ||
                       ((r_phase == btsp_pkg::PH_LENX) && (r_len_left == 2'd1)));
    assign w_finish = (w_start && (w_new_len == '0)) ||
                      (!w_ovf && (r_phase == btsp_pkg::PH_VALUE) &&
                       (r_value_left == 16'd1));
    assign w_match  = (r_tag == i_cfg.search_tag);
    assign w_report = w_finish && (!i_cfg.search_enable || w_match);

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_tag         = r_tag;
        n_cons        = r_cons;
        n_length      = r_length;
        n_len_left    = r_len_left;
        n_value_start = r_value_start;
        n_value_left  = r_value_left;
        w_mid_phase   = r_phase;
        if (w_ovf) begin
            w_mid_phase = btsp_pkg::PH_HALT;
        end else begin
            unique case (r_phase)
                btsp_pkg::PH_SKIP: begin
                    if (!w_filler) begin
                        n_tag  = {8'b0, i_data_byte};
                        n_cons = i_data_byte[btsp_pkg::ConsBit];
                        w_mid_phase = (i_data_byte[4:0] == btsp_pkg::TagMultiMask) ?
                                      btsp_pkg::PH_TAG2 : btsp_pkg::PH_LEN0;
                    end
                end
                btsp_pkg::PH_TAG2: begin
                    n_tag = {r_tag[7:0], i_data_byte};
                    w_mid_phase = w_badtag ? btsp_pkg::PH_HALT : btsp_pkg::PH_LEN0;
                end
                btsp_pkg::PH_LEN0: begin
                    if (w_badlen) begin
                        w_mid_phase = btsp_pkg::PH_HALT;
                    end else if (i_data_byte[7]) begin
                        n_length    = '0;
                        n_len_left  = i_data_byte[1:0];
                        w_mid_phase = btsp_pkg::PH_LENX;
                    end else begin
                        n_length = w_new_len;
                    end
                end
                btsp_pkg::PH_LENX: begin
                    n_length   = w_new_len;
                    n_len_left = r_len_left - 2'd1;
                end
                btsp_pkg::PH_VALUE: begin
                    n_value_left = r_value_left - 16'd1;
                end
                default: begin
                    w_mid_phase = btsp_pkg::PH_HALT;
                end
            endcase
            // length complete: open the value, or close an empty object
            if (w_start) begin
                n_value_start = r_position + 16'd1;
                n_value_left  = w_new_len;
                w_mid_phase   = btsp_pkg::PH_VALUE;
            end
            if (w_finish) begin
                w_mid_phase = (i_cfg.search_enable && w_match) ?
                              btsp_pkg::PH_HALT : btsp_pkg::PH_SKIP;
            end
        end
        n_phase = i_last_byte ? btsp_pkg::PH_SKIP : w_mid_phase;
        if (i_last_byte) begin
            n_position = '0;
        end else if (r_position != btsp_pkg::PosMax) begin
            n_position = r_position + 16'd1;
        end else begin
            n_position = r_position;
        end
    end

    // results
    always_comb begin
        w_prim_res = '0;
        w_tail_res = '0;
        w_prim     = 1'b1;
        priority if (w_ovf) begin
            w_prim_res.status = btsp_pkg::ST_TRUNC;
        end else if (w_badtag) begin
            w_prim_res.status = btsp_pkg::ST_BADTAG;
        end else if (w_badlen) begin
            w_prim_res.status = btsp_pkg::ST_BADLEN;
        end else if (w_report) begin
            w_prim_res.status       = btsp_pkg::ST_OK;
            w_prim_res.tag_value    = r_tag;
            w_prim_res.constructed  = r_cons;
            w_prim_res.value_length = n_length;
            w_prim_res.value_offset = w_start ? n_value_start : r_value_start;
        end else begin
            w_prim = 1'b0;
        end
        w_tail = i_last_byte && (w_mid_phase != btsp_pkg::PH_HALT);
        w_tail_res.status   = (w_mid_phase == btsp_pkg::PH_SKIP) ?
                              btsp_pkg::ST_END : btsp_pkg::ST_TRUNC;
        w_tail_res.run_last = 1'b1;
        w_prim_res.run_last = !w_tail;

        o_push.push_one = i_accept && (w_prim != w_tail);
        o_push.push_two = i_accept && w_prim && w_tail;
        o_push.a        = w_prim ? w_prim_res : w_tail_res;
        o_push.b        = w_tail_res;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= btsp_pkg::PH_SKIP;
            r_position    <= '0;
            r_tag         <= '0;
            r_cons        <= 1'b0;
            r_length      <= '0;
            r_len_left    <= '0;
            r_value_start <= '0;
            r_value_left  <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_position    <= n_position;
            r_tag         <= n_tag;
            r_cons        <= n_cons;
            r_length      <= n_length;
            r_len_left    <= n_len_left;
            r_value_start <= n_value_start;
            r_value_left  <= n_value_left;
        end
    end

endmodule

[hw/rtl/btsp_fifo.sv]
module btsp_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btsp_pkg::t_push   i_push,
    output logic              o_space,
    btsp_res_if.source        o_res
);

    localparam int unsigned Depth = 4;

    btsp_pkg::t_result r_mem [Depth];
    logic [1:0]        r_wr_ptr, r_rd_ptr;
    logic [2:0]        r_count;
    logic              w_pop;
    logic [2:0]        w_push_n;
    btsp_pkg::t_result w_head;

    // the input side stays open while the queue has room for two results
    assign o_space  = (r_count <= 3'(Depth - 2));
    assign w_pop    = o_res.valid && o_res.ready;
    assign w_push_n = i_push.push_two ? 3'd2 : (i_push.push_one ? 3'd1 : 3'd0);

    always_ff @(posedge i_clk) begin
        if (i_push.push_one || i_push.push_two) begin
            r_mem[r_wr_ptr] <= i_push.a;
        end
        if (i_push.push_two) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + w_push_n[1:0];
            r_rd_ptr <= r_rd_ptr + {1'b0, w_pop};
            r_count  <= r_count + w_push_n - {2'b0, w_pop};
        end
    end

    // head of queue drives the result channel
    assign w_head             = r_mem[r_rd_ptr];
    assign o_res.valid        = (r_count != '0);
    assign o_res.status       = w_head.status;
    assign o_res.tag_value    = w_head.tag_value;
    assign o_res.constructed  = w_head.constructed;
    assign o_res.value_length = w_head.value_length;
    assign o_res.value_offset = w_head.value_offset;
    assign o_res.run_last     = w_head.run_last;

endmodule

[test/tlv_result_checker.sv]
`timescale 1ns / 100ps

// Watches the byte and result channels of the TLV parser, tracks the search
// registers from APB writes, predicts the result beats of every accepted
// byte and compares each accepted result beat with the oldest prediction.
module tlv_result_checker
    import btsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    btsp_byte_if        i_byte,
    btsp_res_if         i_res,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    // shadow of the search registers
    logic        search_en;
    logic [15:0] search_tag;

    // parser state
    t_phase      phase;
    logic [15:0] position;
    logic [15:0] tag_reg;
    logic        constructed_reg;
    logic [15:0] length_reg;
    logic [1:0]  length_bytes_left;
    logic [15:0] value_start;
    logic [15:0] value_left;

    t_result     expected_results[$];
    t_result     byte_results[$];
    int          fails = 0;

    function automatic t_result error_result(input t_status code);
        t_result r;
        r = '0;
        r.status = code;
        return r;
    endfunction

    // object complete: report it unless search mode skips it
    task automatic close_object();
        t_result r;
        if (!search_en || tag_reg == search_tag) begin
            r = '0;
            r.status       = ST_OK;
            r.tag_value    = tag_reg;
            r.constructed  = constructed_reg;
            r.value_length = length_reg;
            r.value_offset = value_start;
            byte_results.push_back(r);
            phase = search_en ? PH_HALT : PH_SKIP;
        end else begin
            phase = PH_SKIP;
        end
    endtask

    task automatic open_value(input logic [15:0] pos);
        value_start = pos + 16'd1;
        value_left  = length_reg;
        if (length_reg == 16'd0) begin
            close_object();
        end else begin
            phase = PH_VALUE;
        end
    endtask

    // advance the parser by one byte, queue the results it causes
    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [15:0] pos;
        t_result     r;
        pos = position;
        byte_results.delete();

        if (phase != PH_HALT && pos == PosMax) begin
            byte_results.push_back(error_result(ST_TRUNC));
            phase = PH_HALT;
        end else begin
            case (phase)
                PH_SKIP: begin
                    if (b != FillZero && b != FillOnes) begin
                        tag_reg         = {8'h00, b};
                        constructed_reg = b[ConsBit];
                        phase = (b[4:0] == TagMultiMask) ? PH_TAG2 : PH_LEN0;
                    end
                end
                PH_TAG2: begin
                    tag_reg = {tag_reg[7:0], b};
                    if (b[7]) begin
                        byte_results.push_back(error_result(ST_BADTAG));
                        phase = PH_HALT;
                    end else begin
                        phase = PH_LEN0;
                    end
                end
                PH_LEN0: begin
                    if (!b[7]) begin
                        length_reg = {8'h00, b};
                        open_value(pos);
                    end else if (b == LenLongFlag || b == FillOnes
                                 || b[6:0] > MaxLengthBytes) begin
                        byte_results.push_back(error_result(ST_BADLEN));
                        phase = PH_HALT;
                    end else begin
                        length_reg        = 16'd0;
                        length_bytes_left = b[1:0];
                        phase             = PH_LENX;
                    end
                end
                PH_LENX: begin
                    length_reg        = {length_reg[7:0], b};
                    length_bytes_left = length_bytes_left - 2'd1;
                    if (length_bytes_left == 2'd0) begin
                        open_value(pos);
                    end
                end
                PH_VALUE: begin
                    value_left = value_left - 16'd1;
                    if (value_left == 16'd0) begin
                        close_object();
                    end
                end
                default: phase = PH_HALT;
            endcase
        end

        // final byte closes the buffer
        if (last) begin
            if (phase == PH_SKIP) begin
                byte_results.push_back(error_result(ST_END));
            end else if (phase != PH_HALT) begin
                byte_results.push_back(error_result(ST_TRUNC));
            end
            phase    = PH_SKIP;
            position = 16'd0;
        end else if (pos != PosMax) begin
            position = pos + 16'd1;
        end

        foreach (byte_results[i]) begin
            r = byte_results[i];
            r.run_last = (i == byte_results.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: result beat with none expected: got status %0d tag %h",
                     $time, i_res.status, i_res.tag_value);
            fails++;
        end else begin
            want = expected_results.pop_front();
            check_field("status", 16'(want.status), 16'(i_res.status));
            check_field("tag_value", want.tag_value, i_res.tag_value);
            check_field("constructed", 16'(want.constructed), 16'(i_res.constructed));
            check_field("value_length", want.value_length, i_res.value_length);
            check_field("value_offset", want.value_offset, i_res.value_offset);
            check_field("run_last", 16'(want.run_last), 16'(i_res.run_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            search_en         = 1'b0;
            search_tag        = 16'd0;
            phase             = PH_SKIP;
            position          = 16'd0;
            tag_reg           = 16'd0;
            constructed_reg   = 1'b0;
            length_reg        = 16'd0;
            length_bytes_left = 2'd0;
            value_start       = 16'd0;
            value_left        = 16'd0;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == RegSearchTag) begin
                    search_tag = i_pwdata[15:0];
                end else begin
                    search_en = i_pwdata[0];
                end
            end
            if (i_byte.valid && i_byte.ready) begin
                parse_byte(i_byte.data_byte, i_byte.last_byte);
            end
            if (i_res.valid && i_res.ready) begin
                check_result();
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

[test/tb_ber_tlv_stream_parser.sv]
`timescale 1ns / 100ps

module tb_ber_tlv_stream_parser;
    import btsp_pkg::*;

    // cycles without any accepted beat before the run is declared hung
    localparam int StallLimit = 1000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        recv_ready = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          fail_count;
    int          results_pending;
    int          quiet_cycles = 0;
    logic [7:0]  buffer_bytes[$];
    logic [15:0] tag_pool[4];

    btsp_byte_if byte_ch();
    btsp_res_if  res_ch();

    assign res_ch.ready = recv_ready;

    ber_tlv_stream_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tlv_result_checker results_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (byte_ch),
        .i_res        (res_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    always #1 i_clk = ~i_clk;

    // receiver stalls
    always @(posedge i_clk) begin
        recv_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // hang detection
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == StallLimit) begin
            $display("tb_ber_tlv_stream_parser: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // hold off the sender until every predicted result beat has arrived
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    task automatic send_beat(input logic [7:0] data, input logic last);
        if ($urandom_range(199) == 0) begin
            wait_drained();
        end
        if ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= data;
        byte_ch.last_byte <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    task automatic reg_write(input logic index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // registers change only with the parser idle
    task automatic set_search(input logic enable, input logic [15:0] tag);
        wait_drained();
        repeat (4) @(posedge i_clk);
        reg_write(RegSearchEnable, {31'd0, enable});
        reg_write(RegSearchTag, {16'd0, tag});
    endtask

    task automatic play_buffer();
        foreach (buffer_bytes[i]) begin
            send_beat(buffer_bytes[i], i == buffer_bytes.size() - 1);
        end
    endtask

    task automatic push_tag(input logic [15:0] tag);
        if (tag[15:8] != 8'h00) begin
            buffer_bytes.push_back(tag[15:8]);
        end
        buffer_bytes.push_back(tag[7:0]);
    endtask

    // mix of one- and two-byte tags, so that search mode gets hits
    task automatic new_tag_pool();
        logic [7:0] first;
        foreach (tag_pool[i]) begin
            if ($urandom_range(1) == 1) begin
                tag_pool[i] = {3'($urandom_range(0, 6)), TagMultiMask, 1'b0, 7'($urandom)};
            end else begin
                first = {3'($urandom), 5'($urandom_range(0, 30))};
                if (first == FillZero) begin
                    first = 8'h01;
                end
                tag_pool[i] = {8'h00, first};
            end
        end
    endtask

    // one object, preceded by some filler; with noise, sometimes a broken one
    task automatic add_object(input bit allow_noise);
        int len;
        int pick;
        repeat ($urandom_range(0, 2)) begin
            buffer_bytes.push_back(($urandom_range(1) == 1) ? FillZero : FillOnes);
        end
        if (!allow_noise || $urandom_range(99) < 85) begin
            push_tag(tag_pool[$urandom_range(3)]);
            len = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
            case ($urandom_range(5))
                0: begin
                    buffer_bytes.push_back(LenLongFlag | 8'd1);
                    buffer_bytes.push_back(8'(len));
                end
                1: begin
                    buffer_bytes.push_back(LenLongFlag | 8'd2);
                    buffer_bytes.push_back(8'(len >> 8));
                    buffer_bytes.push_back(8'(len));
                end
                default: buffer_bytes.push_back(8'(len));
            endcase
            repeat (len) buffer_bytes.push_back(8'($urandom));
        end else begin
            case ($urandom_range(3))
                0: repeat ($urandom_range(1, 3)) buffer_bytes.push_back(8'($urandom));
                1: begin
                    // tag running into a third byte
                    buffer_bytes.push_back({3'($urandom_range(0, 6)), TagMultiMask});
                    buffer_bytes.push_back(LenLongFlag | 8'($urandom_range(0, 127)));
                end
                2: begin
                    push_tag(tag_pool[$urandom_range(3)]);
                    pick = $urandom_range(2);
                    buffer_bytes.push_back((pick == 0) ? LenLongFlag :
                                           (pick == 1) ? FillOnes :
                                           8'($urandom_range(131, 254)));
                end
                default: begin
                    // long declared length, usually cut by the final byte
                    push_tag(tag_pool[$urandom_range(3)]);
                    buffer_bytes.push_back(LenLongFlag | 8'd2);
                    buffer_bytes.push_back(8'($urandom));
                    buffer_bytes.push_back(8'($urandom));
                end
            endcase
        end
    endtask

    task automatic send_buffer(input int min_bytes, input bit allow_noise);
        buffer_bytes.delete();
        while (buffer_bytes.size() < min_bytes) begin
            add_object(allow_noise);
        end
        if (allow_noise && $urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                if (buffer_bytes.size() > 1) begin
                    void'(buffer_bytes.pop_back());
                end
            end
        end
        play_buffer();
    endtask

    initial begin
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.last_byte <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= 3'd0;
        pwdata            <= 32'd0;
        i_rst_n           <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 45;

        // filler, one-byte tag with empty value closed by the final byte
        buffer_bytes = '{8'h00, 8'hFF, 8'h01, 8'h00};
        play_buffer();
        // two-byte constructed tag, one-byte long form, then empty object at the end
        buffer_bytes = '{8'h3F, 8'h7F, 8'h81, 8'h02, 8'hAA, 8'hBB, 8'h1F, 8'h00, 8'h00};
        play_buffer();
        // third tag byte, rest of buffer ignored
        buffer_bytes = '{8'hDF, 8'h80, 8'h05};
        play_buffer();
        // refused length forms, one of them on the final byte
        buffer_bytes = '{8'h04, 8'h80, 8'h00};
        play_buffer();
        buffer_bytes = '{8'h04, 8'hFF};
        play_buffer();
        // largest length, object cut short by the final byte
        buffer_bytes = '{8'hE1, 8'h82, 8'hFF, 8'hFF, 8'h01};
        play_buffer();
        // search hit, final byte silent
        set_search(1'b1, 16'h3F7F);
        buffer_bytes = '{8'h3F, 8'h7F, 8'h00, 8'h05};
        play_buffer();

        // random buffers under three stall profiles and several register settings
        for (int profile = 0; profile < 3; profile++) begin
            send_idle_pct = (profile == 0) ? 29 : (profile == 1) ? 45 : 0;
            recv_idle_pct = (profile == 0) ? 45 : (profile == 1) ? 29 : 0;
            for (int round = 0; round < 4; round++) begin
                new_tag_pool();
                case (round)
                    0: set_search(1'b0, 16'h0000);
                    1: set_search(1'b1, tag_pool[$urandom_range(3)]);
                    2: set_search(1'b1, 16'hFFFF);
                    default: set_search(1'b0, 16'($urandom));
                endcase
                repeat (3) send_buffer($urandom_range(1, 16), 1'b1);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_ber_tlv_stream_parser: PASS");
        end else begin
            $display("tb_ber_tlv_stream_parser: FAIL");
        end
        $finish;
    end

endmodule
